// ===== rtl/core/cicdd_pkg.sv =====
`default_nettype none

package cicdd_pkg;

  // Default sizes of the grid and of the subbox tiling.
  localparam int GRID_SIZE_DEF    = 64;
  localparam int SUBBOX_COUNT_DEF = 4;

  // Field widths.
  localparam int POS_W     = 24;
  localparam int IDX_W     = 18;
  localparam int WGT_W     = 24;
  localparam int BOX_W     = 2;
  localparam int CELL_W    = 40;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;
  localparam int SHARE_W   = 17;  // trilinear share, 0 .. 1.0 in Q1.16
  localparam int ADD_W     = 25;  // share times weight, rounded
  localparam int RND_W     = 26;
  localparam int PROD_W    = 42;

  localparam logic [WGT_W-1:0]         ONE_Q16   = 24'h01_0000;
  localparam logic [SHARE_W-1:0]       ONE_SHARE = 17'h1_0000;
  localparam logic signed [CELL_W-1:0] CELL_MAX  = 40'sh7F_FFFF_FFFF;
  localparam logic signed [CELL_W-1:0] CELL_RST  = 40'shFF_FFFF_0000;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BOX_X  = 3'd0;
  localparam cfg_idx_t CFG_BOX_Y  = 3'd1;
  localparam cfg_idx_t CFG_BOX_Z  = 3'd2;
  localparam cfg_idx_t CFG_WEIGHT = 3'd3;

  // Item kinds.
  localparam logic KIND_DEPOSIT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_RUN,
    ST_DRAIN,
    ST_READ,
    ST_READW,
    ST_RESP
  } state_t;

  // Round half up and drop sixteen fraction bits.
  function automatic logic [RND_W-1:0] rnd16(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + PROD_W'(32768);
    return s[PROD_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cicdd_ram.sv =====
`default_nettype none

module cicdd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cic_density_deposit_top.sv =====
`default_nettype none

// Channel   Direction  Beat contents                                  Handshake
// in_       input      kind, pos_x, pos_y, pos_z, cell_index          in_valid / in_ready
// out_      output     accepted, cell_value                           out_valid / out_ready
// cfg_      input      register index, write data                     cfg_valid / cfg_ready
//
// A deposit passes through a split state, issues the eight corner updates to the single
// write port of the grid memory, and then drains the multiply and read-modify-write
// pipeline. A rejected deposit goes from the split straight to the response, and a read
// waits for the grid read data. After reset a clearing pass writes -1.0 into every cell,
// during which no item is taken; configuration writes are always taken. A result waits
// in the output register while the next beat is taken.
module cic_density_deposit_top #(
  parameter int GRID_SIZE    = cicdd_pkg::GRID_SIZE_DEF,
  parameter int SUBBOX_COUNT = cicdd_pkg::SUBBOX_COUNT_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,

  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic                                    in_kind,
  input  wire logic [cicdd_pkg::POS_W-1:0]             in_pos_x,
  input  wire logic [cicdd_pkg::POS_W-1:0]             in_pos_y,
  input  wire logic [cicdd_pkg::POS_W-1:0]             in_pos_z,
  input  wire logic [cicdd_pkg::IDX_W-1:0]             in_cell_index,

  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic                                         out_accepted,
  output logic signed [cicdd_pkg::CELL_W-1:0]          out_cell_value,

  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [cicdd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [cicdd_pkg::WGT_W-1:0]             cfg_data
);

  import cicdd_pkg::*;

  localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(GRID_SIZE);
  localparam int SP_W       = 36;
  localparam logic [SP_W-1:0]        SPAN_U = SP_W'(GRID_SIZE) << FRAC_W;
  localparam logic signed [SP_W-1:0] SPAN_S = SPAN_U;

  // Configuration registers.
  logic [BOX_W-1:0] box_r [3];
  logic [WGT_W-1:0] weight_r;

  // Control state.
  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [2:0]    corner_r, corner_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          v_p1_r, v_p2_r, v_p3_r;

  // Item and split registers.
  logic [POS_W-1:0] pos_r [3];
  logic [IDX_W-1:0] cell_index_r;
  logic [CW-1:0]    lo_r [3];
  logic [CW-1:0]    hi_r [3];
  logic [FRAC_W-1:0] fr_r [3];

  // Pending and output results.
  logic              pend_acc_r, pend_acc_nxt;
  logic [CELL_W-1:0] pend_val_r, pend_val_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic [CELL_W-1:0] out_val_r, out_val_nxt;

  // Corner pipeline.
  logic [SHARE_W-1:0] a_p1_r, wz_p1_r, b_p2_r;
  logic [ADD_W-1:0]   add_p3_r;
  logic [AW-1:0]      addr_p1_r, addr_p2_r, addr_p3_r;

  // Memory ports.
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data, rd_data;

  // Split logic.
  logic signed [SP_W-1:0] p_s [3];
  logic [2:0]             inside_s;
  logic [CW-1:0]          cell_s [3];
  logic                   box_ok;
  logic                   keep_s;

  // Corner select and products.
  logic [CW-1:0]      xs, ys, zs;
  logic [SHARE_W-1:0] wxs, wys, wzs;
  logic [AW-1:0]      addr_p0;
  logic [33:0]        prod_a, prod_b;
  logic [40:0]        prod_c;
  logic [CELL_W:0]    sum_p3;
  logic [CELL_W-1:0]  sat_p3;
  logic [31:0]        idx32;
  logic               idx_in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0] <= '0;
      box_r[1] <= '0;
      box_r[2] <= '0;
      weight_r <= ONE_Q16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOX_X:  box_r[0] <= cfg_data[BOX_W-1:0];
        CFG_BOX_Y:  box_r[1] <= cfg_data[BOX_W-1:0];
        CFG_BOX_Z:  box_r[2] <= cfg_data[BOX_W-1:0];
        CFG_WEIGHT: weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Subtract the subbox offset, keep only points strictly inside the grid of a legal
  // subbox, and take the lower cell, its periodic upper neighbor and fraction per axis.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_s[a]      = $signed(SP_W'(pos_r[a]) - SP_W'(box_r[a]) * SPAN_U);
      inside_s[a] = (p_s[a] > $signed(SP_W'(0))) && (p_s[a] < SPAN_S);
      cell_s[a]   = p_s[a][CW+FRAC_W-1:FRAC_W];
    end
    box_ok = (32'(box_r[0]) < 32'(SUBBOX_COUNT)) && (32'(box_r[1]) < 32'(SUBBOX_COUNT)) &&
             (32'(box_r[2]) < 32'(SUBBOX_COUNT));
    keep_s = box_ok && (&inside_s);
  end

  // Corner bit 0 picks the x neighbor, bit 1 the y neighbor and bit 2 the z neighbor.
  always_comb begin
    xs  = corner_r[0] ? hi_r[0] : lo_r[0];
    ys  = corner_r[1] ? hi_r[1] : lo_r[1];
    zs  = corner_r[2] ? hi_r[2] : lo_r[2];
    wxs = corner_r[0] ? SHARE_W'(fr_r[0]) : ONE_SHARE - SHARE_W'(fr_r[0]);
    wys = corner_r[1] ? SHARE_W'(fr_r[1]) : ONE_SHARE - SHARE_W'(fr_r[1]);
    wzs = corner_r[2] ? SHARE_W'(fr_r[2]) : ONE_SHARE - SHARE_W'(fr_r[2]);
    addr_p0 = (AW'(xs) * AW'(GRID_SIZE) + AW'(ys)) * AW'(GRID_SIZE) + AW'(zs);
    prod_a  = 34'(wxs) * 34'(wys);
    prod_b  = 34'(a_p1_r) * 34'(wz_p1_r);
    prod_c  = 41'(b_p2_r) * 41'(weight_r);
  end

  // The add is never negative, so only the upper limit can be crossed.
  always_comb begin
    sum_p3 = {rd_data[CELL_W-1], rd_data} + (CELL_W+1)'(add_p3_r);
    sat_p3 = (sum_p3[CELL_W] != sum_p3[CELL_W-1]) ? CELL_MAX : sum_p3[CELL_W-1:0];
  end

  assign idx32        = 32'(cell_index_r);
  assign idx_in_range = idx32 < 32'(CELL_COUNT);

  always_comb begin
    wr_en   = (state_r == ST_CLEAR) || v_p3_r;
    wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_p3_r;
    wr_data = (state_r == ST_CLEAR) ? CELL_RST : sat_p3;
    rd_en   = (state_r == ST_READ) || v_p2_r;
    rd_addr = (state_r == ST_READ) ? idx32[AW-1:0] : addr_p2_r;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    corner_nxt    = corner_r;
    out_valid_nxt = out_valid_r;
    pend_acc_nxt  = pend_acc_r;
    pend_val_nxt  = pend_val_r;
    out_acc_nxt   = out_acc_r;
    out_val_nxt   = out_val_r;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = (in_kind == KIND_READ) ? ST_READ : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        pend_val_nxt = '0;
        if (keep_s) begin
          state_nxt = ST_RUN;
        end else begin
          pend_acc_nxt = 1'b0;
          state_nxt    = ST_RESP;
        end
      end
      ST_RUN: begin
        corner_nxt = corner_r + 3'd1;
        if (corner_r == 3'd7) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(v_p1_r || v_p2_r || v_p3_r)) begin
          pend_acc_nxt = 1'b1;
          state_nxt    = ST_RESP;
        end
      end
      ST_READ: begin
        state_nxt = ST_READW;
      end
      ST_READW: begin
        pend_acc_nxt = 1'b0;
        pend_val_nxt = idx_in_range ? rd_data : '0;
        state_nxt    = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = pend_acc_r;
          out_val_nxt   = pend_val_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      corner_r    <= '0;
      out_valid_r <= 1'b0;
      v_p1_r      <= 1'b0;
      v_p2_r      <= 1'b0;
      v_p3_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      corner_r    <= corner_nxt;
      out_valid_r <= out_valid_nxt;
      v_p1_r      <= (state_r == ST_RUN);
      v_p2_r      <= v_p1_r;
      v_p3_r      <= v_p2_r;
    end
  end

  always_ff @(posedge clk) begin
    pend_acc_r <= pend_acc_nxt;
    pend_val_r <= pend_val_nxt;
    out_acc_r  <= out_acc_nxt;
    out_val_r  <= out_val_nxt;
    if (in_valid && in_ready) begin
      pos_r[0]     <= in_pos_x;
      pos_r[1]     <= in_pos_y;
      pos_r[2]     <= in_pos_z;
      cell_index_r <= in_cell_index;
    end
    if (state_r == ST_SPLIT) begin
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= cell_s[a];
        hi_r[a] <= (cell_s[a] == CW'(GRID_SIZE - 1)) ? '0 : cell_s[a] + CW'(1);
        fr_r[a] <= p_s[a][FRAC_W-1:0];
      end
    end
    a_p1_r    <= SHARE_W'(rnd16(PROD_W'(prod_a)));
    wz_p1_r   <= wzs;
    addr_p1_r <= addr_p0;
    b_p2_r    <= SHARE_W'(rnd16(PROD_W'(prod_b)));
    addr_p2_r <= addr_p1_r;
    add_p3_r  <= ADD_W'(rnd16(PROD_W'(prod_c)));
    addr_p3_r <= addr_p2_r;
  end

  cicdd_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_cell_value = $signed(out_val_r);

  // The clearing pass owns the write port alone.
  a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !v_p3_r)
    else $error("corner update reached the grid during the clearing pass");

  // A read never meets a write to the same cell, so no forwarding is needed.
  a_no_rw_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("grid read and write to the same cell in one cycle");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SPLIT || state_r == ST_READ))
    else $error("accepted beat did not start a split or a read");

  a_corner_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> (corner_r == 3'd0))
    else $error("corner counter not parked outside the issue phase");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESP))
    else $error("result register loaded outside the response state");

endmodule

`default_nettype wire

// ===== test/tb_cic_density_deposit_top.sv =====
`timescale 1ns / 1ps

module tb_cic_density_deposit_top;
  import cicdd_pkg::*;

  // Grid geometry as the block is built with its default parameters.
  localparam int GRID     = GRID_SIZE_DEF;
  localparam int SUBBOXES = SUBBOX_COUNT_DEF;
  localparam int CELLS    = GRID * GRID * GRID;
  localparam int Q_ONE    = 2 ** FRAC_W;
  localparam int FRAC_MAX = Q_ONE - 1;
  // Length of one subbox edge in Q8.16 position units.
  localparam int SPAN     = GRID * Q_ONE;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 90;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  // The clearing pass after reset accepts nothing while it writes every cell, so the
  // watchdog has to outlast it with a healthy margin.
  localparam int WATCHDOG_LIMIT = 4 * CELLS + 10000;

  typedef struct {
    logic                     accepted;
    logic signed [CELL_W-1:0] cell_value;
  } cell_beat_t;

  // Scoreboard: keeps its own copy of the density grid and the registers,
  // predicts the result beat of each accepted input beat, and checks result
  // beats in order against those predictions.
  class density_scoreboard;
    longint                density[];
    logic [BOX_W-1:0]      box_x, box_y, box_z;
    logic [WGT_W-1:0]      weight;
    cell_beat_t            owed[$];
    int                    mismatches;
    int                    beats_checked;

    function new();
      density = new[CELLS];
      foreach (density[i]) density[i] = longint'(CELL_RST);
      box_x = '0;
      box_y = '0;
      box_z = '0;
      weight = ONE_Q16;
      mismatches = 0;
      beats_checked = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void load_reg(input cfg_idx_t idx, input logic [WGT_W-1:0] data);
      case (idx)
        CFG_BOX_X:  box_x = data[BOX_W-1:0];
        CFG_BOX_Y:  box_y = data[BOX_W-1:0];
        CFG_BOX_Z:  box_z = data[BOX_W-1:0];
        CFG_WEIGHT: weight = data;
        default: ;
      endcase
    endfunction

    function longint round_q16(input longint p);
      return (p + Q_ONE / 2) >>> FRAC_W;
    endfunction

    // Removes the subbox offset; a coordinate on or outside the grid faces is dropped.
    function bit split_axis(input logic [POS_W-1:0] pos, input logic [BOX_W-1:0] box,
                            output int cell_no, output longint frac);
      longint p;
      p = longint'(pos) - longint'(box) * SPAN;
      if (p <= 0 || p >= SPAN) return 1'b0;
      cell_no = int'(p >>> FRAC_W);
      frac = p & FRAC_MAX;
      return 1'b1;
    endfunction

    function void accumulate(input int x, input int y, input int z, input longint add);
      int     at;
      longint v;
      at = (x * GRID + y) * GRID + z;
      v = density[at];
      if (add > longint'(CELL_MAX) - v) v = longint'(CELL_MAX);
      else v += add;
      density[at] = v;
    endfunction

    function void note_item(input logic kind, input logic [POS_W-1:0] px,
                            input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz,
                            input logic [IDX_W-1:0] idx);
      cell_beat_t       beat;
      logic [POS_W-1:0] pos [3];
      logic [BOX_W-1:0] box [3];
      int               cell_no [3];
      int               corner [3][2];
      longint           frac [3];
      longint           share [3][2];
      longint           ab, abc, gain;
      bit               kept;
      beat.accepted = 1'b0;
      beat.cell_value = '0;
      if (kind == KIND_READ) begin
        if (idx < CELLS) beat.cell_value = CELL_W'(density[idx]);
      end else begin
        pos = '{px, py, pz};
        box = '{box_x, box_y, box_z};
        kept = box_x < SUBBOXES && box_y < SUBBOXES && box_z < SUBBOXES;
        for (int a = 0; a < 3; a++)
          if (kept) kept = split_axis(pos[a], box[a], cell_no[a], frac[a]);
        if (kept) begin
          beat.accepted = 1'b1;
          for (int a = 0; a < 3; a++) begin
            corner[a][0] = cell_no[a];
            corner[a][1] = (cell_no[a] + 1) % GRID;
            share[a][0] = Q_ONE - frac[a];
            share[a][1] = frac[a];
          end
          for (int k = 0; k < 2; k++)
            for (int j = 0; j < 2; j++)
              for (int i = 0; i < 2; i++) begin
                ab = round_q16(share[0][i] * share[1][j]);
                abc = round_q16(ab * share[2][k]);
                gain = round_q16(abc * longint'(weight));
                accumulate(corner[0][i], corner[1][j], corner[2][k], gain);
              end
        end
      end
      owed.push_back(beat);
    endfunction

    function void check_beat(input logic acc, input logic signed [CELL_W-1:0] val);
      cell_beat_t want;
      beats_checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Result beat %0d with nothing expected: accepted=%0b cell_value=%0d",
                   beats_checked, acc, val);
      end else begin
        want = owed.pop_front();
        if (want.accepted !== acc || want.cell_value !== val) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"Result beat %0d mismatch: expected accepted=%0b cell_value=%0d,",
                      " got accepted=%0b cell_value=%0d"},
                     beats_checked, want.accepted, want.cell_value, acc, val);
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_kind;
  logic [POS_W-1:0]         in_pos_x;
  logic [POS_W-1:0]         in_pos_y;
  logic [POS_W-1:0]         in_pos_z;
  logic [IDX_W-1:0]         in_cell_index;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_accepted;
  logic signed [CELL_W-1:0] out_cell_value;
  logic                     cfg_valid;
  logic                     cfg_ready;
  cfg_idx_t                 cfg_index;
  logic [WGT_W-1:0]         cfg_data;

  density_scoreboard sb;

  // Idling controls for the sender (main process) and the receiver, and the watchdog's idle count.
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  // The subbox that the current phase aims its well-formed particles at.
  logic [BOX_W-1:0] aim_box [3];

  cic_density_deposit_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_cell_value (out_cell_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: every handshake is observed at the rising edge, using the values
  // that were settled before the edge. Result beats are checked before a new
  // input beat is noted, since a result can only belong to an earlier beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_beat(out_accepted, out_cell_value);
      if (in_valid && in_ready)
        sb.note_item(in_kind, in_pos_x, in_pos_y, in_pos_z, in_cell_index);
      if (cfg_valid && cfg_ready) sb.load_reg(cfg_index, cfg_data);
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog: the run is hung if no beat of any kind moves for too long.
  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver. Normally ready; stalls in random bursts while the phase allows it.
  // On request it holds off for one long stretch so that the result register
  // fills, the block backs up and the sender sees in_ready drop.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Offers one beat and returns at the edge where it is taken. Valid is left
  // high so that a following beat can go out back to back; an optional gap
  // drops it first for a random burst of cycles.
  task automatic send_item(input logic kind, input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz,
                           input logic [IDX_W-1:0] idx);
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // Unused fields of a beat carry random junk, which the block must ignore.
  task automatic send_deposit(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic [POS_W-1:0] pz);
    send_item(KIND_DEPOSIT, px, py, pz, IDX_W'($urandom));
  endtask

  task automatic send_probe(input logic [IDX_W-1:0] idx);
    send_item(KIND_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), idx);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [WGT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all four registers plus every index past the last one, which
  // must be ignored. The box writes carry random bits above the index field.
  task automatic program_regs(input logic [BOX_W-1:0] bx, input logic [BOX_W-1:0] by,
                              input logic [BOX_W-1:0] bz, input logic [WGT_W-1:0] w);
    write_reg(CFG_BOX_X, WGT_W'({$urandom, bx}));
    write_reg(CFG_BOX_Y, WGT_W'({$urandom, by}));
    write_reg(CFG_BOX_Z, WGT_W'({$urandom, bz}));
    write_reg(CFG_WEIGHT, w);
    for (int i = CFG_WEIGHT + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(cfg_idx_t'(i), WGT_W'($urandom));
    cfg_valid <= 1'b0;
    aim_box = '{bx, by, bz};
  endtask

  // Waits until every predicted result has arrived, polling the scoreboard on the clock.
  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [IDX_W-1:0] flat_index(input int x, input int y, input int z);
    return IDX_W'((x * GRID + y) * GRID + z);
  endfunction

  // A small corner region that straddles the periodic wrap. Particles and
  // reads concentrate here so that cells pile up several deposits each.
  function automatic int hot_cell();
    case ($urandom_range(0, 3))
      0:       return GRID - 2;
      1:       return GRID - 1;
      2:       return 0;
      default: return 1;
    endcase
  endfunction

  // A position strictly inside the given subbox, either in the hot region
  // (with the fraction pinned to its extremes now and then) or anywhere.
  function automatic logic [POS_W-1:0] aim_axis(input logic [BOX_W-1:0] box, input bit hot);
    int base_q;
    int local_q;
    base_q = int'(box) * SPAN;
    if (hot) begin
      case ($urandom_range(0, 9))
        0:       local_q = hot_cell() * Q_ONE;
        1:       local_q = hot_cell() * Q_ONE + FRAC_MAX;
        default: local_q = hot_cell() * Q_ONE + $urandom_range(0, FRAC_MAX);
      endcase
      if (local_q == 0) local_q = 1;
    end else begin
      local_q = $urandom_range(1, SPAN - 1);
    end
    return POS_W'(base_q + local_q);
  endfunction

  // Noise coordinate: fully random, exactly on either face of the subbox, or a
  // legal one, so that single-axis rejects show up as well.
  function automatic logic [POS_W-1:0] noisy_axis(input logic [BOX_W-1:0] box);
    case ($urandom_range(0, 3))
      0:       return POS_W'($urandom);
      1:       return POS_W'(int'(box) * SPAN);
      2:       return POS_W'(int'(box) * SPAN + SPAN);
      default: return aim_axis(box, 1'b0);
    endcase
  endfunction

  // Mostly well-formed particles and reads of cells they touched; the rest is
  // reads anywhere in the grid and particles that are likely to be rejected.
  task automatic send_random_item();
    int r;
    bit hot;
    r = $urandom_range(0, 99);
    hot = $urandom_range(0, 9) < 7;
    if (r < 55) begin
      send_deposit(aim_axis(aim_box[0], hot), aim_axis(aim_box[1], hot),
                   aim_axis(aim_box[2], hot));
    end else if (r < 80) begin
      send_probe(flat_index(hot_cell(), hot_cell(), hot_cell()));
    end else if (r < 88) begin
      send_probe(IDX_W'($urandom));
    end else begin
      send_deposit(noisy_axis(aim_box[0]), noisy_axis(aim_box[1]), noisy_axis(aim_box[2]));
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_DEPOSIT;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_pos_z <= '0;
    in_cell_index <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BOX_X;
    cfg_data <= '0;
    aim_box = '{default: '0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats, under the reset configuration (subbox 0, weight 1.0).
    // The block is still clearing the grid, so these wait for in_ready.
    // First the two ends of the grid must read back as -1.0.
    send_probe('0);
    send_probe(IDX_W'(CELLS - 1));
    // A particle exactly on a cell corner puts the whole weight into one cell
    // and a zero share into its seven neighbors.
    send_deposit(POS_W'(Q_ONE), POS_W'(Q_ONE), POS_W'(Q_ONE));
    send_probe(flat_index(1, 1, 1));
    send_probe(flat_index(2, 1, 1));
    // Just below the upper faces: the upper neighbors wrap around to cell 0.
    send_deposit(POS_W'(SPAN - 1), POS_W'(SPAN - 1), POS_W'(SPAN - 1));
    send_probe(flat_index(0, 0, 0));
    send_probe(flat_index(GRID - 1, GRID - 1, GRID - 1));
    send_probe(flat_index(0, GRID - 1, 0));
    // The smallest position that is still inside.
    send_deposit(POS_W'(1), POS_W'(1), POS_W'(1));
    send_probe(flat_index(0, 0, 0));
    // On a face along each axis in turn: rejected, grid untouched.
    send_deposit('0, POS_W'(Q_ONE), POS_W'(Q_ONE));
    send_deposit(POS_W'(SPAN), POS_W'(Q_ONE), POS_W'(Q_ONE));
    send_deposit(POS_W'(Q_ONE), '0, POS_W'(Q_ONE));
    send_deposit(POS_W'(Q_ONE), POS_W'(SPAN), POS_W'(Q_ONE));
    send_deposit(POS_W'(Q_ONE), POS_W'(Q_ONE), '0);
    send_deposit(POS_W'(Q_ONE), POS_W'(Q_ONE), POS_W'(SPAN));
    // Far outside subbox 0.
    send_deposit('1, '1, '1);
    // Half-cell fractions split the weight evenly over all eight cells.
    send_deposit(POS_W'((GRID / 2) * Q_ONE + Q_ONE / 2), POS_W'((GRID / 2) * Q_ONE + Q_ONE / 2),
                 POS_W'((GRID / 2) * Q_ONE + Q_ONE / 2));
    send_probe(flat_index(GRID / 2 + 1, GRID / 2, GRID / 2 + 1));
    send_probe(flat_index(1, 1, 1));
    in_valid <= 1'b0;

    // Random phases, each under its own register setting. Registers are only
    // touched once the block has gone quiet after the last result beat.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph)
        0:       program_regs(BOX_W'(SUBBOXES - 1), BOX_W'(SUBBOXES - 1),
                              BOX_W'(SUBBOXES - 1), '1);
        1:       program_regs(BOX_W'($urandom_range(0, SUBBOXES - 1)),
                              BOX_W'($urandom_range(0, SUBBOXES - 1)),
                              BOX_W'($urandom_range(0, SUBBOXES - 1)), '0);
        2:       program_regs('0, '0, '0, ONE_Q16);
        default: program_regs(BOX_W'($urandom_range(0, SUBBOXES - 1)),
                              BOX_W'($urandom_range(0, SUBBOXES - 1)),
                              BOX_W'($urandom_range(0, SUBBOXES - 1)), WGT_W'($urandom));
      endcase

      // Idling varies from phase to phase; the closing phases run flat out.
      tx_gap_pct = (ph < 6) ? (ph % 3) * 15 : 0;
      rx_stall_pct = (ph < 6) ? (ph % 3) * 15 : 0;

      // In the last subbox the top of the position range is a legal particle
      // in the top corner cell, with all its upper neighbors wrapping.
      if (ph == 0) send_deposit('1, '1, '1);
      // Long receiver hold-off while the sender keeps offering beats.
      if (ph == 3) hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Sender pause until the block has handed back every result.
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_random_item();
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
